// ----- rtl/core/nnc_pkg.sv -----
// ----------------------------------------------------------------------------
// nnc_pkg
// Shared types and constants for the nearest neighbour classifier.
// ----------------------------------------------------------------------------
package nnc_pkg;

  // field widths of the stream payloads
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned FIDX_W     = 4;
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned LABEL_W    = 8;
  localparam int unsigned DIST_W     = 37;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 56;

  // configuration port
  localparam int unsigned CFG_DATA_W    = 9;
  localparam int unsigned SCOUNT_W      = 9;
  localparam int unsigned FCOUNT_W      = 5;
  localparam logic        CFG_SAMPLE_COUNT  = 1'b0;
  localparam logic        CFG_FEATURE_COUNT = 1'b1;

  // kind of an input transaction
  localparam logic ACTION_LOAD  = 1'b0;
  localparam logic ACTION_QUERY = 1'b1;

  // control sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_LABEL,
    ST_OUT
  } state_t;

  // tag that travels with each distance term down the datapath
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } pipe_tag_t;

endpackage

// ----- rtl/core/nearest_neighbour_classifier_top.sv -----
// ----------------------------------------------------------------------------
// nearest_neighbour_classifier_top
// One-nearest-neighbour classifier on squared Euclidean distance.
// ----------------------------------------------------------------------------
// Training features are written one per transaction (tuser = load) into a
// sample memory, each also writing its sample's label; query features
// (tuser = query) go to a query memory. The query transaction with tlast set
// starts a search over sample_count samples and feature_count features and
// returns one result: lowest index at the minimum distance, its label and the
// distance (saturated to 37 bits). Loads and plain query features are accepted
// while idle. After a final query feature the input stays stalled until the
// result has been handed on, including any wait on the result side:
// the single read port of the sample memory is walked one feature per cycle,
// followed by a four-stage subtract, square, accumulate and compare pipeline
// and one label memory read. Entries that were never written read back as
// undefined. Configuration may be written only while no search is running.
// ----------------------------------------------------------------------------
module nearest_neighbour_classifier_top
  import nnc_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES  = 256,
  parameter int unsigned MAX_FEATURES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // slave side, tdata from bit 0: sample_index, feature_index,
  // feature_value, class_label, zero fill
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,   // action
  input  logic                  s_axis_tlast,   // query_done
  // master side, tdata from bit 0: nearest_index, nearest_label,
  // nearest_distance_sq, zero fill
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // configuration write port
  input  logic                  cfg_wr_en,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned DEPTH = MAX_SAMPLES * MAX_FEATURES;
  localparam int unsigned SW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned FW    = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ACC_W = SQ_W + $clog2(MAX_FEATURES);

  // input fields
  logic [IDX_W-1:0]   in_sample_index;
  logic [FIDX_W-1:0]  in_feature_index;
  logic [VAL_W-1:0]   in_feature_value;
  logic [LABEL_W-1:0] in_class_label;
  logic               in_accept;
  logic               sample_in_range;
  logic               feature_in_range;
  logic [AW-1:0]      wr_addr;

  assign in_sample_index  = s_axis_tdata[7:0];
  assign in_feature_index = s_axis_tdata[11:8];
  assign in_feature_value = s_axis_tdata[27:12];
  assign in_class_label   = s_axis_tdata[35:28];
  assign in_accept        = s_axis_tvalid && s_axis_tready;
  assign sample_in_range  = 32'(in_sample_index) < 32'(MAX_SAMPLES);
  assign feature_in_range = 32'(in_feature_index) < 32'(MAX_FEATURES);
  assign wr_addr = AW'(32'(in_sample_index) * 32'(MAX_FEATURES)
                       + 32'(in_feature_index));

  // configuration registers
  logic [SCOUNT_W-1:0] sample_count;
  logic [FCOUNT_W-1:0] feature_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count  <= SCOUNT_W'(1);
      feature_count <= FCOUNT_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SAMPLE_COUNT:  sample_count  <= cfg_data[SCOUNT_W-1:0];
        CFG_FEATURE_COUNT: feature_count <= cfg_data[FCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped last sample and last feature of a search
  logic [SW-1:0] ns_last_next;
  logic [FW-1:0] nf_last_next;

  always_comb begin
    if (sample_count == '0) begin
      ns_last_next = '0;
    end else if (17'(sample_count) > 17'(MAX_SAMPLES)) begin
      ns_last_next = SW'(MAX_SAMPLES - 1);
    end else begin
      ns_last_next = SW'(sample_count - SCOUNT_W'(1));
    end
    if (feature_count == '0) begin
      nf_last_next = '0;
    end else if (9'(feature_count) > 9'(MAX_FEATURES)) begin
      nf_last_next = FW'(MAX_FEATURES - 1);
    end else begin
      nf_last_next = FW'(feature_count - FCOUNT_W'(1));
    end
  end

  // sequencer
  state_t    state;
  state_t    state_next;
  logic      start;
  logic      issue;
  logic      walk_done;
  logic      out_load;
  logic      pipe_busy;
  pipe_tag_t p1;
  pipe_tag_t p2;
  pipe_tag_t p3;
  pipe_tag_t p4;

  logic [SW-1:0] s_cnt;
  logic [FW-1:0] f_cnt;
  logic [AW-1:0] base;
  logic [SW-1:0] ns_last;
  logic [FW-1:0] nf_last;

  assign pipe_busy = p1.valid || p2.valid || p3.valid || p4.valid;
  assign walk_done = (s_cnt == ns_last) && (f_cnt == nf_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    start         = 1'b0;
    issue         = 1'b0;
    out_load      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && s_axis_tuser == ACTION_QUERY && s_axis_tlast) begin
          start      = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        issue = 1'b1;
        if (walk_done) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_next = ST_LABEL;
        end
      end
      ST_LABEL: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sample and feature walk
  always_ff @(posedge clk) begin
    if (start) begin
      s_cnt   <= '0;
      f_cnt   <= '0;
      base    <= '0;
      ns_last <= ns_last_next;
      nf_last <= nf_last_next;
    end else if (issue) begin
      if (f_cnt == nf_last) begin
        f_cnt <= '0;
        s_cnt <= s_cnt + SW'(1);
        base  <= base + AW'(MAX_FEATURES);
      end else begin
        f_cnt <= f_cnt + FW'(1);
      end
    end
  end

  // memories
  logic [VAL_W-1:0]   sample_mem [DEPTH];
  logic [LABEL_W-1:0] label_mem  [MAX_SAMPLES];
  logic [VAL_W-1:0]   query_mem  [MAX_FEATURES];
  logic [VAL_W-1:0]   sample_rdata;
  logic [VAL_W-1:0]   query_rdata;
  logic [LABEL_W-1:0] label_rdata;
  logic [AW-1:0]      rd_addr;
  logic [SW-1:0]      best_i;

  assign rd_addr = base + AW'(f_cnt);

  always_ff @(posedge clk) begin
    if (in_accept && s_axis_tuser == ACTION_LOAD && sample_in_range && feature_in_range) begin
      sample_mem[wr_addr]              <= in_feature_value;
      label_mem[SW'(in_sample_index)] <= in_class_label;
    end
    sample_rdata <= sample_mem[rd_addr];
    label_rdata  <= label_mem[best_i];
  end

  always_ff @(posedge clk) begin
    if (in_accept && s_axis_tuser == ACTION_QUERY && feature_in_range) begin
      query_mem[FW'(in_feature_index)] <= in_feature_value;
    end
    query_rdata <= query_mem[f_cnt];
  end

  // tags follow the reads down the datapath
  logic [SW-1:0] p1_s;
  logic [SW-1:0] p2_s;
  logic [SW-1:0] p3_s;
  logic [SW-1:0] p4_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= '0;
      p2 <= '0;
      p3 <= '0;
      p4 <= '0;
    end else begin
      p1 <= '{valid: issue, first: (f_cnt == '0), last: (f_cnt == nf_last)};
      p2 <= p1;
      p3 <= p2;
      p4 <= '{valid: p3.valid && p3.last, first: p3.first, last: p3.last};
    end
  end

  always_ff @(posedge clk) begin
    p1_s <= s_cnt;
    p2_s <= p1_s;
    p3_s <= p2_s;
    p4_s <= p3_s;
  end

  // difference, square, accumulate
  logic signed [VAL_W:0]     diff;
  logic signed [2*VAL_W+1:0] prod;
  logic [SQ_W-1:0]           sq;
  logic [ACC_W-1:0]          acc;
  logic [ACC_W-1:0]          best_d;

  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    diff <= $signed({query_rdata[VAL_W-1], query_rdata})
          - $signed({sample_rdata[VAL_W-1], sample_rdata});
    sq   <= prod[SQ_W-1:0];
    if (p3.valid) begin
      acc <= (p3.first ? '0 : acc) + ACC_W'(sq);
    end
  end

  // running minimum, strict compare keeps the lowest index on ties
  always_ff @(posedge clk) begin
    if (p4.valid && (p4_s == '0 || acc < best_d)) begin
      best_d <= acc;
      best_i <= p4_s;
    end
  end

  // distance saturation
  logic [DIST_W-1:0] dist_sat;

  generate
    if (ACC_W > DIST_W) begin : g_sat
      assign dist_sat = (|best_d[ACC_W-1:DIST_W]) ? '1 : best_d[DIST_W-1:0];
    end else begin : g_nosat
      assign dist_sat = DIST_W'(best_d);
    end
  endgenerate

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {(OUT_DATA_W - DIST_W - 2*IDX_W)'(0), dist_sat, label_rdata,
                       IDX_W'(best_i)};
    end
  end

  // checks
  a_issue_from_search: assert property (@(posedge clk) disable iff (rst)
    p1.valid |-> $past(state == ST_SEARCH))
    else $error("distance term issued outside a search");

  a_label_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LABEL) |-> !pipe_busy)
    else $error("label read while distance terms still in flight");

  a_query_starts_search: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_axis_tuser == ACTION_QUERY && s_axis_tlast) |=> (state == ST_SEARCH))
    else $error("final query feature did not start a search");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && m_axis_tvalid && !m_axis_tready) |=> (state == ST_OUT))
    else $error("pending result overwritten");

endmodule
